// ===== src/rv64ie_pkg.sv =====
// ----------------------------------------------------------------------------
// rv64ie_pkg
// Shared constants, state codes and the execute result record of the RV64I
// execute unit.
// ----------------------------------------------------------------------------
package rv64ie_pkg;

  localparam int NumRegsDefault = 32;
  localparam int CsrEntries     = 4096;
  localparam int CsrAw          = $clog2(CsrEntries);

  localparam logic [63:0] StartAddressReset = 64'h0000_0000_8000_0000;
  localparam logic [63:0] StackTopReset     = 64'h0000_0000_8800_0000;

  // Configuration register indexes.
  localparam logic CfgStartAddress = 1'b0;
  localparam logic CfgStackTop     = 1'b1;

  // Item kinds.
  localparam logic FuncExec     = 1'b0;
  localparam logic FuncLoadData = 1'b1;

  // Memory request codes.
  localparam logic [1:0] MemNone  = 2'd0;
  localparam logic [1:0] MemRead  = 2'd1;
  localparam logic [1:0] MemWrite = 2'd2;

  // Major opcodes.
  localparam logic [6:0] OpLoad   = 7'h03;
  localparam logic [6:0] OpStore  = 7'h23;
  localparam logic [6:0] OpImm    = 7'h13;
  localparam logic [6:0] OpImm32  = 7'h1b;
  localparam logic [6:0] OpReg    = 7'h33;
  localparam logic [6:0] OpReg32  = 7'h3b;
  localparam logic [6:0] OpLui    = 7'h37;
  localparam logic [6:0] OpAuipc  = 7'h17;
  localparam logic [6:0] OpBranch = 7'h63;
  localparam logic [6:0] OpJal    = 7'h6f;
  localparam logic [6:0] OpJalr   = 7'h67;
  localparam logic [6:0] OpSystem = 7'h73;

  localparam logic [6:0] F7Zero = 7'h00;
  localparam logic [6:0] F7Alt  = 7'h20;
  localparam logic [6:0] F7Mul  = 7'h01;
  localparam logic [5:0] F6Sra  = 6'h10;

  // CSR addresses with special handling.
  localparam logic [CsrAw-1:0] CsrSie     = 12'h104;
  localparam logic [CsrAw-1:0] CsrMideleg = 12'h303;
  localparam logic [CsrAw-1:0] CsrMie     = 12'h304;

  typedef enum logic [4:0] {
    S_CLEAR = 5'b00001,
    S_IDLE  = 5'b00010,
    S_EXEC  = 5'b00100,
    S_MUL   = 5'b01000,
    S_WB    = 5'b10000
  } state_t;

  // Everything the execute stage decides for one word.
  typedef struct packed {
    logic             ok;
    logic             is_mul;
    logic [63:0]      npc;
    logic [1:0]       mop;
    logic [63:0]      maddr;
    logic [1:0]       msz;
    logic [63:0]      mdata;
    logic [4:0]       wb_reg;
    logic [63:0]      wv;
    logic             set_pend;
    logic             clr_pend;
    logic [4:0]       pend_dest;
    logic [2:0]       pend_kind;
    logic             cw;
    logic [CsrAw-1:0] cw_addr;
    logic [63:0]      cw_data;
  } exec_res_t;

endpackage

// ===== src/rv64ie_in_if.sv =====
// ----------------------------------------------------------------------------
// rv64ie_in_if
// Input channel: one instruction or one load-data word per handshake.
// ----------------------------------------------------------------------------
interface rv64ie_in_if;
  logic        valid;
  logic        ready;
  logic        func;
  logic [31:0] instr;
  logic [63:0] load_data;

  modport source (output valid, output func, output instr, output load_data,
                  input ready);
  modport sink (input valid, input func, input instr, input load_data,
                output ready);
endinterface

// ===== src/rv64ie_out_if.sv =====
// ----------------------------------------------------------------------------
// rv64ie_out_if
// Output channel: one result word per executed input word.
// ----------------------------------------------------------------------------
interface rv64ie_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] next_pc;
  logic [1:0]  mem_op;
  logic [63:0] mem_addr;
  logic [1:0]  mem_sz;
  logic [63:0] mem_data;
  logic [4:0]  wb_reg;
  logic [63:0] wb_value;
  logic        illegal;

  modport source (output valid, output next_pc, output mem_op, output mem_addr,
                  output mem_sz, output mem_data, output wb_reg,
                  output wb_value, output illegal, input ready);
  modport sink (input valid, input next_pc, input mem_op, input mem_addr,
                input mem_sz, input mem_data, input wb_reg, input wb_value,
                input illegal, output ready);
endinterface

// ===== src/rv64ie_exec.sv =====
// ----------------------------------------------------------------------------
// rv64ie_exec
// Decode and execute of one word: ALU, branch, address and CSR update logic.
// ----------------------------------------------------------------------------
module rv64ie_exec #(
  parameter int NUM_REGS = rv64ie_pkg::NumRegsDefault
) (
  input  logic                        func,
  input  logic [31:0]                 instr,
  input  logic [63:0]                 load_data,
  input  logic [63:0]                 pc,
  input  logic [63:0]                 a,
  input  logic [63:0]                 b,
  input  logic [63:0]                 csr_a,
  input  logic [63:0]                 csr_b,
  input  logic                        load_pending,
  input  logic [4:0]                  pend_dest,
  input  logic [2:0]                  pend_kind,
  output rv64ie_pkg::exec_res_t       res
);

  localparam logic [5:0] NumRegsW = 6'(NUM_REGS);

  always_comb begin
    logic [6:0]  op;
    logic [4:0]  rd;
    logic [2:0]  f3;
    logic [4:0]  rs1;
    logic [6:0]  f7;
    logic [5:0]  f6;
    logic [5:0]  sh;
    logic [4:0]  sh5;
    logic [63:0] iimm;
    logic [63:0] simm;
    logic [63:0] bimm;
    logic [63:0] jimm;
    logic [63:0] uimm;
    logic [31:0] w32;
    logic [63:0] sum;
    logic [63:0] src;
    logic [63:0] t;
    logic [63:0] cv;
    logic        wr;
    logic        ok;
    logic        tk;
    logic [4:0]  dst;
    op   = instr[6:0];
    rd   = instr[11:7];
    f3   = instr[14:12];
    rs1  = instr[19:15];
    f7   = instr[31:25];
    f6   = instr[31:26];
    sh   = instr[25:20];
    sh5  = instr[24:20];
    iimm = {{52{instr[31]}}, instr[31:20]};
    simm = {{52{instr[31]}}, instr[31:25], instr[11:7]};
    bimm = {{51{instr[31]}}, instr[31], instr[7], instr[30:25], instr[11:8], 1'b0};
    jimm = {{43{instr[31]}}, instr[31], instr[19:12], instr[20], instr[30:21], 1'b0};
    uimm = {{32{instr[31]}}, instr[31:12], 12'h000};
    w32  = '0;
    sum  = '0;
    src  = '0;
    t    = '0;
    cv   = '0;
    wr   = 1'b0;
    ok   = 1'b1;
    tk   = 1'b0;
    res  = '0;
    res.npc = pc + 64'd4;

    if (func == rv64ie_pkg::FuncLoadData) begin
      if (!load_pending) begin
        ok = 1'b0;
      end else begin
        res.npc      = pc;
        res.clr_pend = 1'b1;
        rd           = pend_dest;
        wr           = 1'b1;
        case (pend_kind)
          3'd0:    res.wv = {{56{load_data[7]}}, load_data[7:0]};
          3'd1:    res.wv = {{48{load_data[15]}}, load_data[15:0]};
          3'd2:    res.wv = {{32{load_data[31]}}, load_data[31:0]};
          3'd4:    res.wv = {56'h0, load_data[7:0]};
          3'd5:    res.wv = {48'h0, load_data[15:0]};
          3'd6:    res.wv = {32'h0, load_data[31:0]};
          default: res.wv = load_data;
        endcase
      end
    end else if (load_pending) begin
      ok = 1'b0;
    end else begin
      case (op)
        rv64ie_pkg::OpLoad: begin
          if (f3 == 3'd7) begin
            ok = 1'b0;
          end else begin
            res.mop       = rv64ie_pkg::MemRead;
            res.maddr     = a + iimm;
            res.msz       = f3[1:0];
            res.set_pend  = 1'b1;
            res.pend_dest = rd;
            res.pend_kind = f3;
          end
        end
        rv64ie_pkg::OpStore: begin
          if (f3[2]) begin
            ok = 1'b0;
          end else begin
            res.mop   = rv64ie_pkg::MemWrite;
            res.msz   = f3[1:0];
            res.maddr = a + simm;
            case (f3[1:0])
              2'd0:    res.mdata = {56'h0, b[7:0]};
              2'd1:    res.mdata = {48'h0, b[15:0]};
              2'd2:    res.mdata = {32'h0, b[31:0]};
              default: res.mdata = b;
            endcase
          end
        end
        rv64ie_pkg::OpImm: begin
          wr = 1'b1;
          case (f3)
            3'd0: res.wv = a + iimm;
            3'd1: begin
              if (f6 != 6'h00) ok = 1'b0;
              else res.wv = a << sh;
            end
            3'd2: res.wv = {63'h0, $signed(a) < $signed(iimm)};
            3'd3: res.wv = {63'h0, a < iimm};
            3'd4: res.wv = a ^ iimm;
            3'd5: begin
              if (f6 == 6'h00) res.wv = a >> sh;
              else if (f6 == rv64ie_pkg::F6Sra) res.wv = $signed(a) >>> sh;
              else ok = 1'b0;
            end
            3'd6:    res.wv = a | iimm;
            default: res.wv = a & iimm;
          endcase
        end
        rv64ie_pkg::OpImm32: begin
          wr = 1'b1;
          if (f3 == 3'd0) begin
            sum    = a + iimm;
            res.wv = {{32{sum[31]}}, sum[31:0]};
          end else if (f3 == 3'd1 && f7 == rv64ie_pkg::F7Zero) begin
            w32    = a[31:0] << sh5;
            res.wv = {{32{w32[31]}}, w32};
          end else if (f3 == 3'd5 && f7 == rv64ie_pkg::F7Zero) begin
            w32    = a[31:0] >> sh5;
            res.wv = {{32{w32[31]}}, w32};
          end else if (f3 == 3'd5 && f7 == rv64ie_pkg::F7Alt) begin
            res.wv = $signed({{32{a[31]}}, a[31:0]}) >>> sh5;
          end else begin
            ok = 1'b0;
          end
        end
        rv64ie_pkg::OpReg: begin
          wr = 1'b1;
          if (f7 == rv64ie_pkg::F7Zero) begin
            case (f3)
              3'd0:    res.wv = a + b;
              3'd1:    res.wv = a << b[5:0];
              3'd2:    res.wv = {63'h0, $signed(a) < $signed(b)};
              3'd3:    res.wv = {63'h0, a < b};
              3'd4:    res.wv = a ^ b;
              3'd5:    res.wv = a >> b[5:0];
              3'd6:    res.wv = a | b;
              default: res.wv = a & b;
            endcase
          end else if (f7 == rv64ie_pkg::F7Alt && f3 == 3'd0) begin
            res.wv = a - b;
          end else if (f7 == rv64ie_pkg::F7Alt && f3 == 3'd5) begin
            res.wv = $signed(a) >>> b[5:0];
          end else if (f7 == rv64ie_pkg::F7Mul && f3 == 3'd0) begin
            res.is_mul = 1'b1;
          end else begin
            ok = 1'b0;
          end
        end
        rv64ie_pkg::OpReg32: begin
          wr = 1'b1;
          if (f3 == 3'd0 && f7 == rv64ie_pkg::F7Zero) begin
            w32    = a[31:0] + b[31:0];
            res.wv = {{32{w32[31]}}, w32};
          end else if (f3 == 3'd0 && f7 == rv64ie_pkg::F7Alt) begin
            w32    = a[31:0] - b[31:0];
            res.wv = {{32{w32[31]}}, w32};
          end else if (f3 == 3'd1 && f7 == rv64ie_pkg::F7Zero) begin
            w32    = a[31:0] << b[4:0];
            res.wv = {{32{w32[31]}}, w32};
          end else if (f3 == 3'd5 && f7 == rv64ie_pkg::F7Zero) begin
            w32    = a[31:0] >> b[4:0];
            res.wv = {{32{w32[31]}}, w32};
          end else if (f3 == 3'd5 && f7 == rv64ie_pkg::F7Alt) begin
            res.wv = $signed({{32{a[31]}}, a[31:0]}) >>> b[4:0];
          end else begin
            ok = 1'b0;
          end
        end
        rv64ie_pkg::OpLui: begin
          wr     = 1'b1;
          res.wv = uimm;
        end
        rv64ie_pkg::OpAuipc: begin
          wr     = 1'b1;
          res.wv = pc + uimm;
        end
        rv64ie_pkg::OpBranch: begin
          case (f3)
            3'd0:    tk = a == b;
            3'd1:    tk = a != b;
            3'd4:    tk = $signed(a) < $signed(b);
            3'd5:    tk = $signed(a) >= $signed(b);
            3'd6:    tk = a < b;
            3'd7:    tk = a >= b;
            default: ok = 1'b0;
          endcase
          if (tk) res.npc = pc + bimm;
        end
        rv64ie_pkg::OpJal: begin
          wr      = 1'b1;
          res.wv  = pc + 64'd4;
          res.npc = pc + jimm;
        end
        rv64ie_pkg::OpJalr: begin
          if (f3 != 3'd0) begin
            ok = 1'b0;
          end else begin
            wr      = 1'b1;
            res.wv  = pc + 64'd4;
            sum     = a + iimm;
            res.npc = {sum[63:1], 1'b0};
          end
        end
        rv64ie_pkg::OpSystem: begin
          if (f3[1:0] == 2'd0) begin
            ok = 1'b0;
          end else begin
            src = f3[2] ? {59'h0, rs1} : a;
            // SIE is a view of MIE through the delegation mask.
            t = (instr[31:20] == rv64ie_pkg::CsrSie) ? (csr_a & csr_b) : csr_a;
            wr     = 1'b1;
            res.wv = t;
            case (f3[1:0])
              2'd1: begin
                res.cw = 1'b1;
                cv     = src;
              end
              2'd2: begin
                res.cw = rs1 != 5'd0;
                cv     = t | src;
              end
              default: begin
                res.cw = rs1 != 5'd0;
                cv     = t & ~src;
              end
            endcase
            if (instr[31:20] == rv64ie_pkg::CsrSie) begin
              res.cw_addr = rv64ie_pkg::CsrMie;
              res.cw_data = (csr_a & ~csr_b) | (cv & csr_b);
            end else begin
              res.cw_addr = instr[31:20];
              res.cw_data = cv;
            end
          end
        end
        default: ok = 1'b0;
      endcase
    end

    dst = ({1'b0, rd} < NumRegsW) ? rd : 5'd0;
    if (wr && dst != 5'd0) begin
      res.wb_reg = dst;
    end else begin
      res.wb_reg = 5'd0;
      res.wv     = '0;
    end
    res.ok = ok;
    if (!ok) begin
      res     = '0;
      res.npc = pc;
    end
  end

endmodule

// ===== src/rv64i_instruction_execute_unit.sv =====
// ----------------------------------------------------------------------------
// rv64i_instruction_execute_unit
// RV64I integer core with Zicsr and mul, one instruction or load-data word
// per input handshake, state held in a register file RAM and a CSR RAM.
// ----------------------------------------------------------------------------
// Flow: an accepted word goes through execute, then write back, and a mul goes
// through the multiply state on the shared 32x32 multiplier between the two.
// Throughput: one word at a time, a new word is taken only after write back.
// Reset: synchronous rst clears control state and then sweeps the 4096-entry
// CSR RAM to zero, one entry per cycle; no word is accepted until it ends.
// ----------------------------------------------------------------------------
module rv64i_instruction_execute_unit #(
  parameter int NUM_REGS = rv64ie_pkg::NumRegsDefault
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_we,
  input  logic                cfg_index,
  input  logic [63:0]         cfg_data,
  rv64ie_in_if.sink           in_ch,
  rv64ie_out_if.source        out_ch
);

  localparam int         RegAw    = $clog2(NUM_REGS);
  localparam logic [5:0] NumRegsW = 6'(NUM_REGS);
  localparam int         CsrAw    = rv64ie_pkg::CsrAw;

  rv64ie_pkg::state_t state;

  // Architectural state held in flops.
  logic [63:0] pc;
  logic [63:0] stack_top;
  logic        load_pending;
  logic [4:0]  pend_dest;
  logic [2:0]  pend_kind;

  // Register file RAM. Entries that were never written since reset read as
  // their reset value, tracked by one valid bit per entry; x2 falls back to
  // the stack top, which also makes a stack_top write take effect at once.
  logic [63:0]        rf_mem [NUM_REGS];
  logic [NUM_REGS-1:0] rf_valid;
  logic [63:0]        rf_rd_a;
  logic [63:0]        rf_rd_b;
  logic               a_ok, a_vld, a_is2;
  logic               b_ok, b_vld, b_is2;
  logic [63:0]        a;
  logic [63:0]        b;

  // CSR RAM: port A reads the addressed CSR (MIE for SIE), port B reads
  // MIDELEG for the SIE view. One write port shared with the reset sweep.
  logic [63:0]       csr_mem [rv64ie_pkg::CsrEntries];
  logic [63:0]       csr_rd_a;
  logic [63:0]       csr_rd_b;
  logic [CsrAw-1:0]  clr_cnt;

  // The accepted word.
  logic        func_q;
  logic [31:0] instr_q;
  logic [63:0] ld_q;

  rv64ie_pkg::exec_res_t res_d;
  rv64ie_pkg::exec_res_t res;

  // Multiply: three 32x32 partial products through one multiplier.
  logic [1:0]  mul_step;
  logic [31:0] mul_x;
  logic [31:0] mul_y;
  logic [63:0] mul_p;
  logic [63:0] prod;

  // Output register.
  logic        out_valid;
  logic        out_free;
  logic [63:0] wb_val;

  logic [4:0]       rs1_in;
  logic [4:0]       rs2_in;
  logic [CsrAw-1:0] caddr_in;
  logic             accept;

  assign accept   = in_ch.valid && in_ch.ready;
  assign in_ch.ready = (state == rv64ie_pkg::S_IDLE);
  assign rs1_in   = in_ch.instr[19:15];
  assign rs2_in   = in_ch.instr[24:20];
  assign caddr_in = in_ch.instr[31:20];
  assign out_free = !out_valid || out_ch.ready;

  // Register file reads are launched on accept, straight from the word.
  always_ff @(posedge clk) begin
    if (accept) begin
      rf_rd_a <= rf_mem[rs1_in[RegAw-1:0]];
      rf_rd_b <= rf_mem[rs2_in[RegAw-1:0]];
      a_ok    <= rs1_in != 5'd0 && {1'b0, rs1_in} < NumRegsW;
      b_ok    <= rs2_in != 5'd0 && {1'b0, rs2_in} < NumRegsW;
      a_vld   <= rf_valid[rs1_in[RegAw-1:0]];
      b_vld   <= rf_valid[rs2_in[RegAw-1:0]];
      a_is2   <= rs1_in == 5'd2;
      b_is2   <= rs2_in == 5'd2;
    end
    if (state == rv64ie_pkg::S_WB && out_free && res.ok && res.wb_reg != 5'd0) begin
      rf_mem[res.wb_reg[RegAw-1:0]] <= wb_val;
    end
  end

  assign a = !a_ok ? 64'h0 : (a_vld ? rf_rd_a : (a_is2 ? stack_top : 64'h0));
  assign b = !b_ok ? 64'h0 : (b_vld ? rf_rd_b : (b_is2 ? stack_top : 64'h0));

  always_ff @(posedge clk) begin
    if (accept) begin
      csr_rd_a <= csr_mem[(caddr_in == rv64ie_pkg::CsrSie) ? rv64ie_pkg::CsrMie : caddr_in];
      csr_rd_b <= csr_mem[rv64ie_pkg::CsrMideleg];
    end
    if (state == rv64ie_pkg::S_CLEAR) begin
      csr_mem[clr_cnt] <= 64'h0;
    end else if (state == rv64ie_pkg::S_WB && out_free && res.ok && res.cw) begin
      csr_mem[res.cw_addr] <= res.cw_data;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      func_q  <= in_ch.func;
      instr_q <= in_ch.instr;
      ld_q    <= in_ch.load_data;
    end
    if (state == rv64ie_pkg::S_EXEC) begin
      res <= res_d;
    end
  end

  rv64ie_exec #(
    .NUM_REGS (NUM_REGS)
  ) u_exec (
    .func         (func_q),
    .instr        (instr_q),
    .load_data    (ld_q),
    .pc           (pc),
    .a            (a),
    .b            (b),
    .csr_a        (csr_rd_a),
    .csr_b        (csr_rd_b),
    .load_pending (load_pending),
    .pend_dest    (pend_dest),
    .pend_kind    (pend_kind),
    .res          (res_d)
  );

  // Low 64 bits of a*b = alo*blo + ((alo*bhi + ahi*blo) << 32).
  always_comb begin
    case (mul_step)
      2'd0: begin
        mul_x = a[31:0];
        mul_y = b[31:0];
      end
      2'd1: begin
        mul_x = a[31:0];
        mul_y = b[63:32];
      end
      default: begin
        mul_x = a[63:32];
        mul_y = b[31:0];
      end
    endcase
    mul_p = mul_x * mul_y;
  end

  always_ff @(posedge clk) begin
    if (state == rv64ie_pkg::S_MUL) begin
      if (mul_step == 2'd0) prod <= mul_p;
      else prod <= prod + {mul_p[31:0], 32'h0};
    end
  end

  assign wb_val = (res.wb_reg == 5'd0) ? 64'h0 : (res.is_mul ? prod : res.wv);

  // Sequencer and control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= rv64ie_pkg::S_CLEAR;
      clr_cnt      <= '0;
      mul_step     <= 2'd0;
      pc           <= rv64ie_pkg::StartAddressReset;
      stack_top    <= rv64ie_pkg::StackTopReset;
      rf_valid     <= '0;
      load_pending <= 1'b0;
      pend_dest    <= 5'd0;
      pend_kind    <= 3'd0;
      out_valid    <= 1'b0;
    end else begin
      // A new result replaces the old one in the cycle the old one leaves.
      if (state == rv64ie_pkg::S_WB && out_free) out_valid <= 1'b1;
      else if (out_ch.ready) out_valid <= 1'b0;
      case (state)
        rv64ie_pkg::S_CLEAR: begin
          clr_cnt <= clr_cnt + 1'b1;
          if (&clr_cnt) state <= rv64ie_pkg::S_IDLE;
        end
        rv64ie_pkg::S_IDLE: begin
          if (accept) state <= rv64ie_pkg::S_EXEC;
        end
        rv64ie_pkg::S_EXEC: begin
          mul_step <= 2'd0;
          if (res_d.ok && res_d.is_mul && res_d.wb_reg != 5'd0) begin
            state <= rv64ie_pkg::S_MUL;
          end else begin
            state <= rv64ie_pkg::S_WB;
          end
        end
        rv64ie_pkg::S_MUL: begin
          mul_step <= mul_step + 2'd1;
          if (mul_step == 2'd2) state <= rv64ie_pkg::S_WB;
        end
        rv64ie_pkg::S_WB: begin
          // Commit only once the output register can take the result.
          if (out_free) begin
            state     <= rv64ie_pkg::S_IDLE;
            if (res.ok) begin
              pc <= res.npc;
              if (res.clr_pend) load_pending <= 1'b0;
              if (res.set_pend) begin
                load_pending <= 1'b1;
                pend_dest    <= res.pend_dest;
                pend_kind    <= res.pend_kind;
              end
              if (res.wb_reg != 5'd0) rf_valid[res.wb_reg[RegAw-1:0]] <= 1'b1;
            end
          end
        end
        default: state <= rv64ie_pkg::S_IDLE;
      endcase
      // The user must write configuration only while idle; the block does not enforce it.
      if (cfg_we) begin
        case (cfg_index)
          rv64ie_pkg::CfgStartAddress: pc <= cfg_data;
          rv64ie_pkg::CfgStackTop: begin
            stack_top   <= cfg_data;
            rf_valid[2] <= 1'b0;
          end
          default: ;
        endcase
      end
    end
  end

  // Result payload, loaded together with out_valid.
  always_ff @(posedge clk) begin
    if (state == rv64ie_pkg::S_WB && out_free) begin
      out_ch.next_pc  <= res.npc;
      out_ch.mem_op   <= res.mop;
      out_ch.mem_addr <= res.maddr;
      out_ch.mem_sz   <= res.msz;
      out_ch.mem_data <= res.mdata;
      out_ch.wb_reg   <= res.wb_reg;
      out_ch.wb_value <= wb_val;
      out_ch.illegal  <= !res.ok;
    end
  end

  assign out_ch.valid = out_valid;

endmodule
